// ----- rtl/pfc_pkg.sv -----
// Shared types and constants for the small-packet flow classifier.
`default_nettype none

package pfc_pkg;

   localparam int FLOW_W      = 10;
   localparam int TICK_W      = 32;
   localparam int TOTAL_W     = 48;
   localparam int CONF_W      = 8;
   localparam int OUTCOME_W   = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int PERIOD_W    = 32;
   localparam int MINPK_W     = 32;
   localparam int LIMIT_W     = 16;
   localparam int MULT_W      = 8;
   localparam int CHUNK_W     = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CONF_W-1:0] CONF_MAX = '1;

   // Result outcome codes.
   localparam logic [OUTCOME_W-1:0] OUTCOME_BYPASSED = 3'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_SNAPSHOT = 3'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_TRUSTED  = 3'd2;
   localparam logic [OUTCOME_W-1:0] OUTCOME_WAITING  = 3'd3;
   localparam logic [OUTCOME_W-1:0] OUTCOME_CLEARED  = 3'd4;
   localparam logic [OUTCOME_W-1:0] OUTCOME_RAISED   = 3'd5;
   localparam logic [OUTCOME_W-1:0] OUTCOME_HELD     = 3'd6;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PKTS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEN_LIMIT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOSE_MULT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRUST      = 3'd5;

   typedef struct packed {
      logic [FLOW_W-1:0]  flow_index;
      logic               direction;
      logic [TICK_W-1:0]  now_tick;
      logic [TOTAL_W-1:0] total_packets;
      logic [TOTAL_W-1:0] total_bytes;
      logic               already_prioritized;
   } pfc_req_type;

   typedef struct packed {
      logic                 mark_flow;
      logic [OUTCOME_W-1:0] outcome;
      logic [CONF_W-1:0]    confidence;
   } pfc_rsp_type;

   // One classified word waiting in the queue between front and back.
   typedef struct packed {
      logic [FLOW_W-1:0]  flow_index;
      logic               direction;
      logic [TICK_W-1:0]  now_tick;
      logic [TOTAL_W-1:0] total_packets;
      logic [TOTAL_W-1:0] total_bytes;
      logic               out_of_range;
      logic               bypass;
   } pfc_work_type;

   typedef struct packed {
      logic                enable;
      logic [PERIOD_W-1:0] period_ticks;
      logic [MINPK_W-1:0]  min_packets;
      logic [LIMIT_W-1:0]  avg_len_limit;
      logic [MULT_W-1:0]   loose_multiplier;
      logic [CONF_W-1:0]   trust_level;
   } pfc_cfg_type;

endpackage

`default_nettype wire

// ----- rtl/pfc_front.sv -----
// Front end: accepts request words, classifies them and queues them for the back end.
`default_nettype none

module pfc_front
   import pfc_pkg::*;
#(
   parameter int FLOW_ENTRIES = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire pfc_req_type  req_data,
   output logic              req_stall,
   input  wire logic         cfg_enable,
   input  wire logic         clearing,
   output logic              work_valid,
   output pfc_work_type      work_data,
   input  wire logic         work_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   pfc_work_type queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   pfc_work_type     entry;
   logic             push;

   // No words are taken while the back end sweeps its tables after reset.
   assign req_stall  = clearing || (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign work_valid = (count_ff != '0);
   assign work_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      entry.flow_index    = req_data.flow_index;
      entry.direction     = req_data.direction;
      entry.now_tick      = req_data.now_tick;
      entry.total_packets = req_data.total_packets;
      entry.total_bytes   = req_data.total_bytes;
      entry.out_of_range  = (32'(req_data.flow_index) >= 32'(FLOW_ENTRIES));
      entry.bypass        = !cfg_enable || req_data.already_prioritized;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (work_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !work_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && work_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/pfc_back.sv -----
// Back end: flow tables, evaluation sequencer, chunked multiplier and result register.
`default_nettype none

module pfc_back
   import pfc_pkg::*;
#(
   parameter int FLOW_ENTRIES = 1024,
   parameter int COUNTER_BITS = 48
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire pfc_cfg_type  cfg,
   output logic              clearing,
   input  wire logic         work_valid,
   input  wire pfc_work_type work_data,
   output logic              work_pop,
   output logic              rsp_valid,
   output pfc_rsp_type       rsp_data,
   input  wire logic         rsp_stall
);

   localparam int MAX_ROWS = 1 << FLOW_W;
   localparam int ROWS     = (FLOW_ENTRIES < MAX_ROWS) ? FLOW_ENTRIES : MAX_ROWS;
   localparam int ROW_W    = $clog2(ROWS);
   localparam int SLOT_W   = ROW_W + 1;
   // Totals are zero-extended or truncated to the counter width, so differences wrap there.
   localparam int CNT_W    = COUNTER_BITS;
   localparam int NCHUNK   = (CNT_W + CHUNK_W - 1) / CHUNK_W;
   localparam int CHUNK_IW = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int PAD_W    = NCHUNK * CHUNK_W;
   localparam int LM_W     = LIMIT_W + MULT_W;
   localparam int PL_W     = PAD_W + LIMIT_W;
   localparam int PLM_W    = PAD_W + LM_W;
   localparam int CMP_W    = (CNT_W > MINPK_W) ? CNT_W : MINPK_W;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_CMP   = 3'd4;

   typedef struct packed {
      logic [1:0]             valid;
      logic [1:0][CONF_W-1:0] conf;
   } meta_row_type;

   typedef struct packed {
      logic [TICK_W-1:0] tick;
      logic [CNT_W-1:0]  packets;
      logic [CNT_W-1:0]  bytes;
   } snap_type;

   // Both directions of a flow share one row, so one read yields both counts.
   meta_row_type meta_mem [ROWS];
   snap_type     snap_mem [2 * ROWS];

   meta_row_type meta_rd_ff;
   snap_type     snap_rd_ff;
   meta_row_type meta_wdata;
   snap_type     snap_wdata;
   logic         meta_we, snap_we;
   logic [ROW_W-1:0]  meta_waddr;
   logic [SLOT_W-1:0] snap_waddr;

   logic [2:0]          state_ff, state_in;
   logic [ROW_W-1:0]    clear_row_ff, clear_row_in;
   pfc_work_type        item_ff, item_in;
   logic [CONF_W-1:0]   conf_ff, conf_in;
   logic [CONF_W-1:0]   oconf_ff, oconf_in;
   logic [PAD_W-1:0]    rp_ff, rp_in;
   logic [CNT_W-1:0]    rb_ff, rb_in;
   logic [CHUNK_IW-1:0] chunk_ff, chunk_in;
   logic [PL_W-1:0]     accl_ff, accl_in;
   logic [PLM_W-1:0]    acclm_ff, acclm_in;
   logic [LM_W-1:0]     loose_limit_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   pfc_rsp_type         rsp_data_ff, rsp_data_in;
   logic                rsp_load;

   logic                     dir;
   logic [CONF_W-1:0]        cur_conf, oth_conf, raised_conf;
   logic [TICK_W-1:0]        tick_diff;
   logic [CNT_W-1:0]         recent_pk, recent_by;
   logic [CHUNK_W-1:0]       chunk_bits;
   logic [CHUNK_W+LIMIT_W-1:0] prod_l;
   logic [CHUNK_W+LM_W-1:0]  prod_lm;
   logic                     is_short, is_loose, oth_trusted;

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign dir         = item_ff.direction;
   assign cur_conf    = meta_rd_ff.conf[dir];
   assign oth_conf    = meta_rd_ff.conf[~dir];
   assign tick_diff   = item_ff.now_tick - snap_rd_ff.tick;
   assign recent_pk   = CNT_W'(item_ff.total_packets) - snap_rd_ff.packets;
   assign recent_by   = CNT_W'(item_ff.total_bytes) - snap_rd_ff.bytes;
   assign chunk_bits  = rp_ff[PAD_W-1 -: CHUNK_W];
   assign prod_l      = chunk_bits * cfg.avg_len_limit;
   assign prod_lm     = chunk_bits * loose_limit_ff;
   assign oth_trusted = (oconf_ff >= cfg.trust_level);
   assign raised_conf = (conf_ff == CONF_MAX) ? CONF_MAX : conf_ff + 1'b1;
   // floor(bytes / packets) < limit is the same as bytes < limit * packets.
   assign is_short    = PL_W'(rb_ff) < accl_ff;
   assign is_loose    = oth_trusted && (PLM_W'(rb_ff) < acclm_ff);

   always_comb begin
      state_in     = state_ff;
      clear_row_in = clear_row_ff;
      item_in      = item_ff;
      conf_in      = conf_ff;
      oconf_in     = oconf_ff;
      rp_in        = rp_ff;
      rb_in        = rb_ff;
      chunk_in     = chunk_ff;
      accl_in      = accl_ff;
      acclm_in     = acclm_ff;
      rsp_load     = 1'b0;
      rsp_data_in  = rsp_data_ff;
      work_pop     = 1'b0;
      meta_we      = 1'b0;
      snap_we      = 1'b0;
      meta_waddr   = item_ff.flow_index[ROW_W-1:0];
      snap_waddr   = {item_ff.flow_index[ROW_W-1:0], dir};
      meta_wdata   = meta_rd_ff;
      snap_wdata.tick    = item_ff.now_tick;
      snap_wdata.packets = CNT_W'(item_ff.total_packets);
      snap_wdata.bytes   = CNT_W'(item_ff.total_bytes);

      case (state_ff)
         ST_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clear_row_ff;
            meta_wdata = '0;
            clear_row_in = clear_row_ff + 1'b1;
            if (clear_row_ff == ROW_W'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (work_valid && (!rsp_valid_ff || !rsp_stall)) begin
               work_pop = 1'b1;
               item_in  = work_data;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
            rsp_load = 1'b1;
            rsp_data_in.mark_flow  = 1'b0;
            rsp_data_in.confidence = cur_conf;
            if (item_ff.out_of_range) begin
               rsp_data_in.outcome    = OUTCOME_BYPASSED;
               rsp_data_in.confidence = '0;
            end else if (item_ff.bypass) begin
               rsp_data_in.outcome = OUTCOME_BYPASSED;
            end else if (!meta_rd_ff.valid[dir]) begin
               rsp_data_in.outcome   = OUTCOME_SNAPSHOT;
               meta_we               = 1'b1;
               meta_wdata.valid[dir] = 1'b1;
               snap_we               = 1'b1;
            end else if (cur_conf >= cfg.trust_level) begin
               rsp_data_in.outcome = OUTCOME_TRUSTED;
            end else if (tick_diff <= cfg.period_ticks) begin
               rsp_data_in.outcome = OUTCOME_WAITING;
            end else if (CMP_W'(recent_pk) > CMP_W'(cfg.min_packets)) begin
               // Enough traffic: form limit * packets a chunk at a time.
               rsp_load = 1'b0;
               state_in = ST_MUL;
               conf_in  = cur_conf;
               oconf_in = oth_conf;
               rp_in    = PAD_W'(recent_pk);
               rb_in    = recent_by;
               chunk_in = '0;
               accl_in  = '0;
               acclm_in = '0;
            end else begin
               rsp_data_in.outcome    = OUTCOME_CLEARED;
               rsp_data_in.confidence = '0;
               meta_we               = 1'b1;
               meta_wdata.conf[dir]  = '0;
               snap_we               = 1'b1;
            end
         end
         ST_MUL: begin
            accl_in  = (accl_ff << CHUNK_W) + PL_W'(prod_l);
            acclm_in = (acclm_ff << CHUNK_W) + PLM_W'(prod_lm);
            rp_in    = rp_ff << CHUNK_W;
            chunk_in = chunk_ff + 1'b1;
            if (chunk_ff == CHUNK_IW'(NCHUNK - 1)) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_IDLE;
            rsp_load = 1'b1;
            meta_we  = 1'b1;
            snap_we  = 1'b1;
            rsp_data_in.mark_flow = 1'b0;
            if (is_short || is_loose) begin
               rsp_data_in.outcome    = OUTCOME_RAISED;
               rsp_data_in.confidence = raised_conf;
               rsp_data_in.mark_flow  = (raised_conf >= cfg.trust_level) && oth_trusted;
               meta_wdata.conf[dir]   = raised_conf;
            end else if (oth_trusted) begin
               rsp_data_in.outcome    = OUTCOME_HELD;
               rsp_data_in.confidence = conf_ff;
            end else begin
               rsp_data_in.outcome    = OUTCOME_CLEARED;
               rsp_data_in.confidence = '0;
               meta_wdata.conf[dir]   = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_row_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_row_ff <= clear_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      conf_ff        <= conf_in;
      oconf_ff       <= oconf_in;
      rp_ff          <= rp_in;
      rb_ff          <= rb_in;
      chunk_ff       <= chunk_in;
      accl_ff        <= accl_in;
      acclm_ff       <= acclm_in;
      rsp_data_ff    <= rsp_data_in;
      loose_limit_ff <= LM_W'(cfg.avg_len_limit) * LM_W'(cfg.loose_multiplier);
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      if (work_pop) begin
         meta_rd_ff <= meta_mem[work_data.flow_index[ROW_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (snap_we) begin
         snap_mem[snap_waddr] <= snap_wdata;
      end
      if (work_pop) begin
         snap_rd_ff <= snap_mem[{work_data.flow_index[ROW_W-1:0], work_data.direction}];
      end
   end

   // No word leaves the queue while the tables are being swept.
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !work_pop)
      else $error("word popped during table clear");

   // A result is only produced into an empty output register.
   a_load_into_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rsp_valid_ff)
      else $error("result register overwritten");

   // Marking a flow only ever comes from a raise.
   a_mark_on_raise: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.mark_flow) |-> (rsp_data_ff.outcome == OUTCOME_RAISED))
      else $error("mark without raise");

   // The multiply phase always ends in the compare step.
   a_mul_flow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |=> ((state_ff == ST_MUL) || (state_ff == ST_CMP)))
      else $error("multiply phase left early");

endmodule

`default_nettype wire

// ----- rtl/small_packet_flow_classifier.sv -----
// Top level of the small-packet flow classifier: configuration registers and front/back.
//
//   Channel  Direction  Handshake              Word
//   req_     in         req_valid / req_stall  pfc_req_type: flow, direction, tick, totals
//   rsp_     out        rsp_valid / rsp_stall  pfc_rsp_type: mark_flow, outcome, confidence
//   csr_     in         csr_valid / csr_ready  csr_index selects a register, csr_data value
//
// In the back end a word that needs no evaluation is popped while the flow tables are read,
// then decided and written back. A word that is evaluated also passes through the chunked
// multiplier, one 16-bit chunk of the recent packet count per cycle, ceil(COUNTER_BITS / 16)
// chunks in all, and then a compare step that decides it and writes back. After reset the
// back end sweeps the per-flow table, one row per cycle, over min(FLOW_ENTRIES, 1024) rows
// (1024 by default); req_stall stays high during the sweep. A two-word queue separates the
// front from the back, so the input keeps taking words while a result waits on rsp_stall,
// until the queue is full; the output register holds its word until it is taken.
`default_nettype none

module small_packet_flow_classifier
   import pfc_pkg::*;
#(
   parameter int FLOW_ENTRIES = 1024,
   parameter int COUNTER_BITS = 48
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire pfc_req_type            req_data,
   output logic                        req_stall,
   output logic                        rsp_valid,
   output pfc_rsp_type                 rsp_data,
   input  wire logic                   rsp_stall,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   // Registers always ready; the user must write only while the block is idle (not enforced).
   pfc_cfg_type  cfg_ff;
   logic         clearing;
   logic         work_valid;
   logic         work_pop;
   pfc_work_type work_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable           <= 1'b1;
         cfg_ff.period_ticks     <= PERIOD_W'(1000);
         cfg_ff.min_packets      <= MINPK_W'(100);
         cfg_ff.avg_len_limit    <= LIMIT_W'(80);
         cfg_ff.loose_multiplier <= MULT_W'(4);
         cfg_ff.trust_level      <= CONF_W'(5);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENABLE:     cfg_ff.enable           <= csr_data[0];
            CSR_PERIOD:     cfg_ff.period_ticks     <= csr_data[PERIOD_W-1:0];
            CSR_MIN_PKTS:   cfg_ff.min_packets      <= csr_data[MINPK_W-1:0];
            CSR_LEN_LIMIT:  cfg_ff.avg_len_limit    <= csr_data[LIMIT_W-1:0];
            CSR_LOOSE_MULT: cfg_ff.loose_multiplier <= csr_data[MULT_W-1:0];
            CSR_TRUST:      cfg_ff.trust_level      <= csr_data[CONF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The front classifies range and bypass at acceptance and queues the word.
   pfc_front #(
      .FLOW_ENTRIES (FLOW_ENTRIES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .cfg_enable (cfg_ff.enable),
      .clearing   (clearing),
      .work_valid (work_valid),
      .work_data  (work_data),
      .work_pop   (work_pop)
   );

   // The back owns the flow tables, the evaluation and the result register.
   pfc_back #(
      .FLOW_ENTRIES (FLOW_ENTRIES),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .clearing   (clearing),
      .work_valid (work_valid),
      .work_data  (work_data),
      .work_pop   (work_pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall)
   );

endmodule

`default_nettype wire

// ----- sim/pfc_result_checker.sv -----
// Result checker for the small-packet flow classifier: predicts each result word and compares.
module pfc_result_checker
   import pfc_pkg::*;
#(
   parameter int FLOW_ENTRIES = 1024,
   parameter int COUNTER_BITS = 48
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire pfc_req_type            req_data,
   input  wire logic                   req_stall,
   input  wire logic                   rsp_valid,
   input  wire pfc_rsp_type            rsp_data,
   input  wire logic                   rsp_stall,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output int                          pending_results,
   output int                          failures
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 2 * FLOW_ENTRIES;
   localparam logic [63:0] COUNT_MASK = (64'd1 << COUNTER_BITS) - 64'd1;

   pfc_cfg_type cfg;

   logic              snap_valid [SLOTS];
   logic [TICK_W-1:0] snap_tick  [SLOTS];
   logic [63:0]       snap_pkts  [SLOTS];
   logic [63:0]       snap_bytes [SLOTS];
   logic [CONF_W-1:0] conf_count [SLOTS];

   pfc_rsp_type predicted_results[$];
   int queued = 0;
   int mismatch_count = 0;

   assign pending_results = queued;
   assign failures = mismatch_count;

   // Works out the result of one accepted word and updates the flow tables.
   function automatic pfc_rsp_type classify_word(pfc_req_type w);
      pfc_rsp_type r;
      int unsigned slot;
      int unsigned peer;
      logic [63:0] pkts;
      logic [63:0] bytes;
      logic [63:0] recent;
      logic [63:0] avg;
      logic [CONF_W-1:0] own;
      logic [CONF_W-1:0] other;
      logic [TICK_W-1:0] elapsed;
      r = '0;
      r.outcome = OUTCOME_BYPASSED;
      if (int'(w.flow_index) >= FLOW_ENTRIES) begin
         return r;
      end
      slot = 2 * w.flow_index + w.direction;
      peer = 2 * w.flow_index + (w.direction ^ 1'b1);
      own = conf_count[slot];
      r.confidence = own;
      if (!cfg.enable || w.already_prioritized) begin
         return r;
      end
      pkts  = 64'(w.total_packets) & COUNT_MASK;
      bytes = 64'(w.total_bytes) & COUNT_MASK;
      if (!snap_valid[slot]) begin
         snap_valid[slot] = 1'b1;
         snap_tick[slot]  = w.now_tick;
         snap_pkts[slot]  = pkts;
         snap_bytes[slot] = bytes;
         r.outcome = OUTCOME_SNAPSHOT;
         return r;
      end
      if (own >= cfg.trust_level) begin
         r.outcome = OUTCOME_TRUSTED;
         return r;
      end
      elapsed = w.now_tick - snap_tick[slot];
      if (elapsed <= cfg.period_ticks) begin
         r.outcome = OUTCOME_WAITING;
         return r;
      end
      other  = conf_count[peer];
      recent = (pkts - snap_pkts[slot]) & COUNT_MASK;
      if (recent > 64'(cfg.min_packets)) begin
         avg = ((bytes - snap_bytes[slot]) & COUNT_MASK) / recent;
         if (avg < 64'(cfg.avg_len_limit) ||
             (other >= cfg.trust_level &&
              avg < 64'(cfg.avg_len_limit) * 64'(cfg.loose_multiplier))) begin
            if (own != CONF_MAX) begin
               own = own + 1'b1;
            end
            r.outcome = OUTCOME_RAISED;
            r.mark_flow = (own >= cfg.trust_level) && (other >= cfg.trust_level);
         end else if (other >= cfg.trust_level) begin
            r.outcome = OUTCOME_HELD;
         end else begin
            own = '0;
            r.outcome = OUTCOME_CLEARED;
         end
      end else begin
         own = '0;
         r.outcome = OUTCOME_CLEARED;
      end
      conf_count[slot] = own;
      snap_tick[slot]  = w.now_tick;
      snap_pkts[slot]  = pkts;
      snap_bytes[slot] = bytes;
      r.confidence = own;
      return r;
   endfunction

   always @(posedge clock) begin
      pfc_rsp_type want;
      if (reset) begin
         cfg.enable           = 1'b1;
         cfg.period_ticks     = PERIOD_W'(1000);
         cfg.min_packets      = MINPK_W'(100);
         cfg.avg_len_limit    = LIMIT_W'(80);
         cfg.loose_multiplier = MULT_W'(4);
         cfg.trust_level      = CONF_W'(5);
         for (int i = 0; i < SLOTS; i++) begin
            snap_valid[i] = 1'b0;
            conf_count[i] = '0;
         end
         predicted_results.delete();
         queued <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENABLE:     cfg.enable           = csr_data[0];
               CSR_PERIOD:     cfg.period_ticks     = csr_data[PERIOD_W-1:0];
               CSR_MIN_PKTS:   cfg.min_packets      = csr_data[MINPK_W-1:0];
               CSR_LEN_LIMIT:  cfg.avg_len_limit    = csr_data[LIMIT_W-1:0];
               CSR_LOOSE_MULT: cfg.loose_multiplier = csr_data[MULT_W-1:0];
               CSR_TRUST:      cfg.trust_level      = csr_data[CONF_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_results.size() == 0) begin
               $display("%0t: expected no word, actual mark=%0d outcome=%0d confidence=%0d",
                        $time, rsp_data.mark_flow, rsp_data.outcome, rsp_data.confidence);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = predicted_results.pop_front();
               if (rsp_data.mark_flow !== want.mark_flow || rsp_data.outcome !== want.outcome ||
                   rsp_data.confidence !== want.confidence) begin
                  $display("%0t: expected mark=%0d outcome=%0d confidence=%0d,",
                           $time, want.mark_flow, want.outcome, want.confidence,
                           " actual mark=%0d outcome=%0d confidence=%0d",
                           rsp_data.mark_flow, rsp_data.outcome, rsp_data.confidence);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            predicted_results.push_back(classify_word(req_data));
         end
         queued <= predicted_results.size();
      end
   end

endmodule

// ----- sim/small_packet_flow_classifier_test.sv -----
// Testbench top for the small-packet flow classifier: clock, reset, stimulus and verdict.
module small_packet_flow_classifier_test
   import pfc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FLOWS      = 1024;
   localparam int COUNT_BITS = 48;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   pfc_req_type            req_data = '0;
   logic                   req_stall;
   logic                   rsp_valid;
   pfc_rsp_type            rsp_data;
   logic                   rsp_stall = 1'b0;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int pending_results;
   int failures;

   // Percent of cycles in which the sender holds back a word and the receiver stalls.
   int idle_pct = 13;
   int stall_pct = 13;

   // The settings currently loaded into the block; stimulus is shaped around them.
   pfc_cfg_type stim_cfg;

   small_packet_flow_classifier #(
      .FLOW_ENTRIES(FLOWS),
      .COUNTER_BITS(COUNT_BITS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_data(req_data),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .rsp_stall(rsp_stall),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   pfc_result_checker #(
      .FLOW_ENTRIES(FLOWS),
      .COUNTER_BITS(COUNT_BITS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_data(req_data),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .rsp_stall(rsp_stall),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .pending_results(pending_results),
      .failures(failures)
   );

   always #6 clock = ~clock;

   // The receiver stalls at random. Stall is redrawn at every edge so that it falls on
   // every phase of the back end's work, including while a result is being decided.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Offers one word, after a random number of idle cycles, and returns at the edge that
   // takes it. Valid is left high so that a following word goes out back to back; only
   // one assignment to valid is ever made in a time step.
   task automatic send_word(pfc_req_type w);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic send_fields(logic [FLOW_W-1:0] flow, logic dir, logic [TICK_W-1:0] tick,
                              logic [TOTAL_W-1:0] pkts, logic [TOTAL_W-1:0] bytes,
                              logic prio);
      pfc_req_type w;
      w.flow_index          = flow;
      w.direction           = dir;
      w.now_tick            = tick;
      w.total_packets       = pkts;
      w.total_bytes         = bytes;
      w.already_prioritized = prio;
      send_word(w);
   endtask

   // Holds the input quiet until every predicted result has been taken. The checker's
   // count is updated at the clock edge, so the task waits for an edge before each read.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_results != 0);
   endtask

   // Writes all six registers while the block is idle. Valid stays high across the
   // writes and is lowered once at the end.
   task automatic apply_config(logic en, logic [PERIOD_W-1:0] period,
                               logic [MINPK_W-1:0] minp, logic [LIMIT_W-1:0] limit,
                               logic [MULT_W-1:0] mult, logic [CONF_W-1:0] trust);
      logic [CSR_DATA_W-1:0] values[6];
      logic [CSR_INDEX_W-1:0] regs[6];
      wait_drained();
      stim_cfg.enable           = en;
      stim_cfg.period_ticks     = period;
      stim_cfg.min_packets      = minp;
      stim_cfg.avg_len_limit    = limit;
      stim_cfg.loose_multiplier = mult;
      stim_cfg.trust_level      = trust;
      regs   = '{CSR_ENABLE, CSR_PERIOD, CSR_MIN_PKTS, CSR_LEN_LIMIT, CSR_LOOSE_MULT, CSR_TRUST};
      values = '{CSR_DATA_W'(en), CSR_DATA_W'(period), CSR_DATA_W'(minp),
                 CSR_DATA_W'(limit), CSR_DATA_W'(mult), CSR_DATA_W'(trust)};
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_data  <= values[i];
         @(posedge clock);
         while (!csr_ready) begin
            @(posedge clock);
         end
      end
      csr_valid <= 1'b0;
   endtask

   // Random traffic on a small pool of flows. Each flow direction keeps its own tick
   // anchor and running totals, so most words are well-formed: either inside the period,
   // or just over one period later with a packet count picked at or below the minimum or
   // above it, and an average length below the length limit, between it and the loose limit,
   // or above both. A few words are fully random noise on arbitrary flows, ticks and totals.
   task automatic run_phase(int count);
      logic [FLOW_W-1:0]  pool_flow[4];
      logic [TICK_W-1:0]  anchor[8];
      logic [TOTAL_W-1:0] pk_total[8];
      logic [TOTAL_W-1:0] by_total[8];
      logic [63:0]        inc;
      logic [63:0]        avg;
      logic [63:0]        loose;
      pfc_req_type        w;
      int                 s;
      int                 k;
      for (int i = 0; i < 4; i++) begin
         pool_flow[i] = FLOW_W'($urandom_range((1 << FLOW_W) - 1, 0));
      end
      for (int i = 0; i < 8; i++) begin
         anchor[i]   = $urandom;
         pk_total[i] = TOTAL_W'({$urandom, $urandom});
         by_total[i] = TOTAL_W'({$urandom, $urandom});
      end
      loose = 64'(stim_cfg.avg_len_limit) * 64'(stim_cfg.loose_multiplier);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 8) begin
            w.flow_index          = FLOW_W'($urandom_range((1 << FLOW_W) - 1, 0));
            w.direction           = $urandom_range(1);
            w.now_tick            = $urandom;
            w.total_packets       = TOTAL_W'({$urandom, $urandom});
            w.total_bytes         = TOTAL_W'({$urandom, $urandom});
            w.already_prioritized = $urandom_range(1);
         end else begin
            s = $urandom_range(7);
            k = $urandom_range(99);
            w.flow_index          = pool_flow[s / 2];
            w.direction           = s[0];
            w.already_prioritized = ($urandom_range(99) < 5);
            if (k < 15) begin
               // Still inside the period: a little traffic piles up for the next look.
               w.now_tick  = anchor[s] + $urandom_range(stim_cfg.period_ticks, 0);
               pk_total[s] = pk_total[s] + TOTAL_W'($urandom_range(3));
               by_total[s] = by_total[s] + TOTAL_W'($urandom_range(200));
            end else begin
               anchor[s]  = anchor[s] + stim_cfg.period_ticks + TICK_W'(1 + $urandom_range(9));
               w.now_tick = anchor[s];
               if (k < 30) begin
                  inc = 64'($urandom_range(stim_cfg.min_packets, 0));
               end else begin
                  inc = 64'(stim_cfg.min_packets) + 64'(1 + $urandom_range(40));
               end
               if (k < 70) begin
                  avg = (stim_cfg.avg_len_limit == 0) ? 64'd0 :
                        64'($urandom_range(32'(stim_cfg.avg_len_limit) - 1, 0));
               end else if (k < 85) begin
                  avg = 64'(stim_cfg.avg_len_limit) +
                        64'($urandom_range(32'(loose - 64'(stim_cfg.avg_len_limit)), 0));
               end else begin
                  avg = loose + 64'($urandom_range(100));
               end
               pk_total[s] = pk_total[s] + TOTAL_W'(inc);
               // The remainder stays below the packet count, so the floored average
               // is the one that was picked.
               by_total[s] = by_total[s] +
                             TOTAL_W'(inc * avg + (64'($urandom) % ((inc == 0) ? 64'd1 : inc)));
            end
            w.total_packets = pk_total[s];
            w.total_bytes   = by_total[s];
         end
         send_word(w);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed words on the last and the first flow. A short period and low limits
      // make every outcome reachable in a few words.
      apply_config(1'b1, 10, 2, 10, 4, 2);
      send_fields(10'd1023, 1'b0, 32'd100, 48'd0, 48'd0, 1'b0);   // first snapshot
      send_fields(10'd1023, 1'b0, 32'd105, 48'd1, 48'd5, 1'b0);   // waiting
      send_fields(10'd1023, 1'b0, 32'd110, 48'd1, 48'd5, 1'b0);   // exactly one period
      send_fields(10'd1023, 1'b0, 32'd111, 48'd2, 48'd0, 1'b0);   // count at the minimum
      send_fields(10'd1023, 1'b0, 32'd122, 48'd5, 48'd29, 1'b0);  // average just below
      send_fields(10'd1023, 1'b0, 32'd133, 48'd8, 48'd59, 1'b0);  // average at the limit
      send_fields(10'd1023, 1'b0, 32'd144, 48'd11, 48'd86, 1'b0);
      send_fields(10'd1023, 1'b0, 32'd155, 48'd14, 48'd113, 1'b0); // reaches trust
      send_fields(10'd1023, 1'b0, 32'd200, 48'd20, 48'd500, 1'b0); // already trusted
      // Reply direction starts at the top of every range so that the tick and the
      // totals wrap. With the original direction trusted, the loose limit applies.
      send_fields(10'd1023, 1'b1, 32'hFFFF_FFF0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFF0, 1'b0);
      send_fields(10'd1023, 1'b1, 32'h0000_0005, 48'd4, 48'd199, 1'b0);  // held
      send_fields(10'd1023, 1'b1, 32'h0000_0020, 48'd9, 48'd349, 1'b0);  // raised, loose
      send_fields(10'd1023, 1'b1, 32'h0000_0040, 48'd14, 48'd499, 1'b0); // flow marked
      send_fields(10'd1023, 1'b0, 32'h0000_0050, 48'd0, 48'd0, 1'b1);    // prioritized
      send_fields(10'd0, 1'b1, 32'd0, 48'd0, 48'd0, 1'b1);
      send_fields(10'd0, 1'b0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
      send_fields(10'd0, 1'b0, 32'h0000_000A, 48'd0, 48'd0, 1'b0);       // wrapped, cleared

      // Disabled: every word passes untouched and reports the stored count.
      apply_config(1'b0, 10, 2, 10, 4, 2);
      send_fields(10'd1023, 1'b0, 32'd300, 48'd50, 48'd50, 1'b0);
      send_fields(10'd1023, 1'b1, 32'd300, 48'd50, 48'd50, 1'b0);

      // Reset values.
      apply_config(1'b1, 1000, 100, 80, 4, 5);
      run_phase(300);

      // A one-tick period, no packet minimum, widest limits, and a long stretch in which
      // neither side idles.
      idle_pct  = 0;
      stall_pct = 0;
      apply_config(1'b1, 1, 0, 16'hFFFF, 8'hFF, 3);
      run_phase(200);
      idle_pct  = 13;
      stall_pct = 13;

      // The period can never pass, and a zero trust level trusts every direction.
      apply_config(1'b1, 32'hFFFF_FFFF, 5, 0, 1, 0);
      run_phase(100);

      // Largest packet minimum and trust level; packet deltas run past 32 bits.
      apply_config(1'b1, 20, 32'hFFFF_FFFF, 300, 2, 8'hFF);
      run_phase(150);

      // Low trust level, so flows get marked often. Midway the sender waits until
      // every result has come back before it goes on.
      apply_config(1'b1, 50, 3, 20, 3, 2);
      run_phase(200);
      wait_drained();
      run_phase(200);

      apply_config(1'b0, 50, 3, 20, 3, 2);
      run_phase(50);

      apply_config(1'b1, $urandom_range(200, 1), $urandom_range(20), $urandom_range(300),
                   $urandom_range(255, 1), $urandom_range(6));
      run_phase(250);

      // Let the last results arrive, then give the block time to show any extra word.
      wait_drained();
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("small_packet_flow_classifier_test passed");
      end else begin
         $display("small_packet_flow_classifier_test failed");
      end
      $finish;
   end

   // A run that hangs on a handshake ends here.
   initial begin
      #5ms;
      $display("small_packet_flow_classifier_test failed");
      $finish;
   end

endmodule
